[src/mvwna_pkg.sv]
`timescale 1ns / 1ps

package mvwna_pkg;

    typedef enum logic [3:0] {
        S_CLR,      // hash table sweep (reset or clear item)
        S_IDLE,
        S_HRD,      // hash slot read
        S_HCHK,     // hash slot compare
        S_CROSS,    // cross product in flight
        S_ARD,      // accumulator read
        S_AWR,      // accumulator saturating write back
        S_NRD,      // normal read for read item
        S_NCHK,
        S_DONE      // hand result to output register
    } t_state;

    localparam logic [1:0] KIND_CORNER = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_UNASG = 2'd2;

    localparam int ACC_W = 48;

endpackage

[src/mvwna_cross.sv]
`timescale 1ns / 1ps

// Sequential cross product (p1 - p0) x (p2 - p0), two multipliers.
module mvwna_cross #(
    parameter int CB = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [3*CB-1:0]         i_p0,
    input  logic [3*CB-1:0]         i_p1,
    input  logic [3*CB-1:0]         i_p2,
    output logic                    o_done,
    output logic signed [2*CB+2:0]  o_nx,
    output logic signed [2*CB+2:0]  o_ny,
    output logic signed [2*CB+2:0]  o_nz
);
    localparam int DW = CB + 1;
    localparam int MW = 2 * DW;
    localparam int NW = MW + 1;

    function automatic logic signed [DW-1:0] f_diff(input logic [CB-1:0] a,
                                                    input logic [CB-1:0] b);
        return $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    endfunction

    logic signed [DW-1:0] ax, ay, az, bx, by, bz;
    logic signed [DW-1:0] m0a, m0b, m1a, m1b;
    logic signed [MW-1:0] r_m0, r_m1;
    logic signed [NW-1:0] diff;
    logic [1:0]           r_step;
    logic                 r_run;
    logic                 r_done;

    assign ax = f_diff(i_p1[CB-1:0],      i_p0[CB-1:0]);
    assign ay = f_diff(i_p1[2*CB-1:CB],   i_p0[2*CB-1:CB]);
    assign az = f_diff(i_p1[3*CB-1:2*CB], i_p0[3*CB-1:2*CB]);
    assign bx = f_diff(i_p2[CB-1:0],      i_p0[CB-1:0]);
    assign by = f_diff(i_p2[2*CB-1:CB],   i_p0[2*CB-1:CB]);
    assign bz = f_diff(i_p2[3*CB-1:2*CB], i_p0[3*CB-1:2*CB]);

    always_comb begin
        unique case (r_step)
            2'd0: begin m0a = ay; m0b = bz; m1a = az; m1b = by; end
            2'd1: begin m0a = az; m0b = bx; m1a = ax; m1b = bz; end
            default: begin m0a = ax; m0b = by; m1a = ay; m1b = bx; end
        endcase
    end

    assign diff = NW'(r_m0) - NW'(r_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= 2'd0;
            end else if (r_run) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0 <= m0a * m0b;
        r_m1 <= m1a * m1b;
        if (r_run) begin
            unique case (r_step)
                2'd1: o_nx <= diff;
                2'd2: o_ny <= diff;
                2'd3: o_nz <= diff;
                default: ;
            endcase
        end
    end

    assign o_done = r_done;

endmodule

[src/mesh_vertex_weld_normal_accumulate.sv]
`timescale 1ns / 1ps
// A corner item probes the hash table; the corner that closes a triangle then runs the cross
//   product and three accumulator read/write passes. A read item reads one accumulator entry.
// Throughput: one item at a time; set by the hash probe chain and the accumulator read/write passes.
// Reset: synchronous active low; a sweep over all 2**(IDW+1) slots invalidates the hash table,
//   no item is taken during it. A clear item runs the same sweep.
module mesh_vertex_weld_normal_accumulate #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic signed [COORD_BITS-1:0]  i_pos_x,
    input  logic signed [COORD_BITS-1:0]  i_pos_y,
    input  logic signed [COORD_BITS-1:0]  i_pos_z,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_read_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [$clog2(MAX_VERTICES)-1:0] o_vertex_id,
    output logic                          o_is_new,
    output logic [1:0]                    o_status,
    output logic signed [47:0]            o_norm_x,
    output logic signed [47:0]            o_norm_y,
    output logic signed [47:0]            o_norm_z
);
    localparam int AW     = mvwna_pkg::ACC_W;
    localparam int IDW    = $clog2(MAX_VERTICES);
    localparam int HW     = IDW + 1;            // hash table is twice the vertex table
    localparam int HDEPTH = 2 ** HW;
    localparam int CNTW   = IDW + 1;
    localparam int PW     = 3 * COORD_BITS;
    localparam int NW     = 2 * COORD_BITS + 3;
    localparam int SW     = ((NW > AW) ? NW : AW) + 1;
    localparam int EW     = 1 + PW + IDW;       // {valid, position, id}
    localparam logic signed [SW-1:0] SMAX = {{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = ~SMAX;

    // XOR fold of the position into a slot number.
    function automatic logic [HW-1:0] f_hash(input logic [PW-1:0] p);
        logic [HW-1:0] h;
        h = '0;
        for (int i = 0; i < PW; i++) begin
            h[i % HW] = h[i % HW] ^ p[i];
        end
        return h;
    endfunction

    function automatic logic [AW-1:0] f_sat(input logic signed [AW-1:0] a,
                                            input logic signed [NW-1:0] n);
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(n);
        if (s > SMAX) begin
            s = SMAX;
        end else if (s < SMIN) begin
            s = SMIN;
        end
        return s[AW-1:0];
    endfunction

    mvwna_pkg::t_state r_state, n_state;

    // Hash table: position -> vertex id, linear probing.
    logic [EW-1:0]  r_hmem [HDEPTH];
    logic [EW-1:0]  r_hrd;
    logic           hwe;
    logic [HW-1:0]  haddr;
    logic [EW-1:0]  hwdata;

    // Accumulators, {x, y, z}; an entry is zeroed when its vertex is created.
    logic [3*AW-1:0] r_amem [MAX_VERTICES];
    logic [3*AW-1:0] r_ard;
    logic            awe;
    logic [IDW-1:0]  awaddr, araddr;
    logic [3*AW-1:0] awdata;

    logic [PW-1:0]   r_pos;
    logic [IDW-1:0]  r_rdidx;
    logic [CNTW-1:0] r_cnt;
    logic [PW-1:0]   r_cpos0, r_cpos1;
    logic [IDW-1:0]  r_cid [3];
    logic [1:0]      r_phase;
    logic            r_drop;
    logic [HW-1:0]   r_slot;
    logic [1:0]      r_k;
    logic            r_boot;

    logic [IDW-1:0]  r_vid;
    logic            r_new;
    logic [1:0]      r_st;
    logic [AW-1:0]   r_nx, r_ny, r_nz;
    logic            r_ov;

    logic            h_valid, h_hit, h_resolve, h_ok, h_close, room;
    logic [IDW-1:0]  h_id;
    logic            rd_ok;
    logic            cross_start, cross_done;
    logic signed [NW-1:0] cnx, cny, cnz;

    assign h_valid   = r_hrd[EW-1];
    assign h_hit     = h_valid && (r_hrd[EW-2:IDW] == r_pos);
    assign h_resolve = h_hit || !h_valid;
    assign room      = r_cnt < CNTW'(MAX_VERTICES);
    assign h_ok      = h_hit || room;
    assign h_id      = h_hit ? r_hrd[IDW-1:0] : r_cnt[IDW-1:0];
    // third corner closes the triangle; any unindexed corner drops it
    assign h_close   = (r_phase == 2'd2) && !r_drop && h_ok;
    assign rd_ok     = {1'b0, r_rdidx} < r_cnt;
    assign cross_start = (r_state == mvwna_pkg::S_HCHK) && h_resolve && h_close;

    mvwna_cross #(.CB(COORD_BITS)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cross_start),
        .i_p0    (r_cpos0),
        .i_p1    (r_cpos1),
        .i_p2    (r_pos),
        .o_done  (cross_done),
        .o_nx    (cnx),
        .o_ny    (cny),
        .o_nz    (cnz)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mvwna_pkg::S_CLR: begin
                if (r_slot == HW'(HDEPTH - 1)) begin
                    n_state = r_boot ? mvwna_pkg::S_IDLE : mvwna_pkg::S_DONE;
                end
            end
            mvwna_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_kind)
                        mvwna_pkg::KIND_CORNER: n_state = mvwna_pkg::S_HRD;
                        mvwna_pkg::KIND_READ:   n_state = mvwna_pkg::S_NRD;
                        mvwna_pkg::KIND_CLEAR:  n_state = mvwna_pkg::S_CLR;
                        default:                n_state = mvwna_pkg::S_DONE;
                    endcase
                end
            end
            mvwna_pkg::S_HRD:  n_state = mvwna_pkg::S_HCHK;
            mvwna_pkg::S_HCHK: begin
                if (!h_resolve) begin
                    n_state = mvwna_pkg::S_HRD;
                end else if (h_close) begin
                    n_state = mvwna_pkg::S_CROSS;
                end else begin
                    n_state = mvwna_pkg::S_DONE;
                end
            end
            mvwna_pkg::S_CROSS: begin
                if (cross_done) begin
                    n_state = mvwna_pkg::S_ARD;
                end
            end
            mvwna_pkg::S_ARD:  n_state = mvwna_pkg::S_AWR;
            mvwna_pkg::S_AWR:  n_state = (r_k == 2'd2) ? mvwna_pkg::S_DONE : mvwna_pkg::S_ARD;
            mvwna_pkg::S_NRD:  n_state = mvwna_pkg::S_NCHK;
            mvwna_pkg::S_NCHK: n_state = mvwna_pkg::S_DONE;
            mvwna_pkg::S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_state = mvwna_pkg::S_IDLE;
                end
            end
            default: n_state = mvwna_pkg::S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        hwe    = 1'b0;
        haddr  = r_slot;
        hwdata = '0;
        awe    = 1'b0;
        awaddr = r_cid[r_k];
        awdata = '0;
        araddr = r_cid[r_k];
        unique case (r_state)
            mvwna_pkg::S_CLR: hwe = 1'b1;
            mvwna_pkg::S_HCHK: begin
                if (!h_valid && room) begin
                    hwe    = 1'b1;
                    hwdata = {1'b1, r_pos, r_cnt[IDW-1:0]};
                    awe    = 1'b1;
                    awaddr = r_cnt[IDW-1:0];
                end
            end
            mvwna_pkg::S_AWR: begin
                awe    = 1'b1;
                awdata = {f_sat(r_ard[3*AW-1:2*AW], cnx),
                          f_sat(r_ard[2*AW-1:AW], cny),
                          f_sat(r_ard[AW-1:0], cnz)};
            end
            mvwna_pkg::S_NRD: araddr = r_rdidx;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            r_hmem[haddr] <= hwdata;
        end
        r_hrd <= r_hmem[haddr];
    end

    always_ff @(posedge i_clk) begin
        if (awe) begin
            r_amem[awaddr] <= awdata;
        end
        r_ard <= r_amem[araddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvwna_pkg::S_CLR;
            r_boot  <= 1'b1;
            r_slot  <= '0;
            r_cnt   <= '0;
            r_phase <= 2'd0;
            r_drop  <= 1'b0;
            r_k     <= 2'd0;
            r_ov    <= 1'b0;
            r_cpos0 <= '0;
            r_cpos1 <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cid[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                mvwna_pkg::S_CLR: begin
                    r_slot <= r_slot + HW'(1);
                    if (r_slot == HW'(HDEPTH - 1)) begin
                        r_boot <= 1'b0;
                    end
                end
                mvwna_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_pos   <= {i_pos_z, i_pos_y, i_pos_x};
                        r_rdidx <= i_read_index;
                        r_vid   <= '0;
                        r_new   <= 1'b0;
                        r_st    <= mvwna_pkg::ST_OK;
                        r_nx    <= '0;
                        r_ny    <= '0;
                        r_nz    <= '0;
                        // clear sweeps from slot zero
                        r_slot  <= (i_kind == mvwna_pkg::KIND_CLEAR) ? '0 :
                                   f_hash({i_pos_z, i_pos_y, i_pos_x});
                        if (i_kind == mvwna_pkg::KIND_CLEAR) begin
                            r_cnt   <= '0;
                            r_phase <= 2'd0;
                            r_drop  <= 1'b0;
                            r_cpos0 <= '0;
                            r_cpos1 <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_cid[i] <= '0;
                            end
                        end
                    end
                end
                mvwna_pkg::S_HCHK: begin
                    if (!h_resolve) begin
                        r_slot <= r_slot + HW'(1);
                    end else begin
                        r_vid <= h_ok ? h_id : '0;
                        r_new <= !h_hit && h_ok;
                        r_st  <= h_ok ? mvwna_pkg::ST_OK : mvwna_pkg::ST_FULL;
                        r_cid[r_phase] <= h_ok ? h_id : '0;
                        if (!h_hit && h_ok) begin
                            r_cnt <= r_cnt + CNTW'(1);
                        end
                        r_k <= 2'd0;
                        if (r_phase != 2'd2) begin
                            if (r_phase == 2'd0) begin
                                r_cpos0 <= r_pos;
                            end else begin
                                r_cpos1 <= r_pos;
                            end
                            r_phase <= r_phase + 2'd1;
                            r_drop  <= r_drop || !h_ok;
                        end else begin
                            r_phase <= 2'd0;
                            r_drop  <= 1'b0;
                        end
                    end
                end
                mvwna_pkg::S_AWR: r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                mvwna_pkg::S_NCHK: begin
                    r_vid <= r_rdidx;
                    if (rd_ok) begin
                        r_nx <= r_ard[3*AW-1:2*AW];
                        r_ny <= r_ard[2*AW-1:AW];
                        r_nz <= r_ard[AW-1:0];
                    end else begin
                        r_st <= mvwna_pkg::ST_UNASG;
                    end
                end
                default: ;
            endcase
            // output register: result waits here while the next item is taken
            if ((r_state == mvwna_pkg::S_DONE) && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == mvwna_pkg::S_DONE) && (!r_ov || i_ready)) begin
            o_vertex_id <= r_vid;
            o_is_new    <= r_new;
            o_status    <= r_st;
            o_norm_x    <= r_nx;
            o_norm_y    <= r_ny;
            o_norm_z    <= r_nz;
        end
    end

    assign o_ready = (r_state == mvwna_pkg::S_IDLE);
    assign o_valid = r_ov;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(MAX_VERTICES)) else $error("vertex count overflow");
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3) else $error("corner phase out of range");
    a_hwe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hwe |-> (r_state == mvwna_pkg::S_CLR || r_state == mvwna_pkg::S_HCHK))
        else $error("hash write outside sweep or insert");
    a_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cross_done |-> (r_state == mvwna_pkg::S_CROSS))
        else $error("cross product finished outside its wait state");

endmodule
